// ----- design/sfcp_pkg.sv -----
`default_nettype none

package sfcp_pkg;

    // CRC-16/MODBUS: reflected polynomial, all-ones seed, no final xor.
    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Byte positions within one frame; the counter covers 0..9.
    localparam int unsigned CNT_W = 4;
    localparam logic [CNT_W-1:0] CRC_LO_IDX = 4'd8;
    localparam logic [CNT_W-1:0] CRC_HI_IDX = 4'd9;

    // Four channel words; chan_zero sits in the lowest bits.
    typedef struct packed {
        logic [15:0] chan_three;
        logic [15:0] chan_two;
        logic [15:0] chan_one;
        logic [15:0] chan_zero;
    } sample_t;

    // Handoff from the input buffer to the serializer.
    typedef struct packed {
        logic    valid;
        sample_t sample;
    } hold_t;

endpackage

`default_nettype wire

// ----- design/sfcp_crc_step.sv -----
`default_nettype none

// Folds one byte into the running CRC, eight bit steps, least significant first.
module sfcp_crc_step (
    input  wire logic [15:0] crc_in,
    input  wire logic [7:0]  byte_in,
    output logic      [15:0] crc_out
);

    always_comb begin
        logic [15:0] acc;
        acc = crc_in ^ {8'h00, byte_in};
        for (int b = 0; b < 8; b++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ sfcp_pkg::CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        crc_out = acc;
    end

endmodule

`default_nettype wire

// ----- design/sfcp_in_buf.sv -----
`default_nettype none

// One-deep input register that takes a new item while a frame is still going out.
module sfcp_in_buf (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire sfcp_pkg::sample_t s_tdata,
    input  wire logic             take,
    output sfcp_pkg::hold_t       hold
);

    logic              valid_reg;
    logic              valid_next;
    sfcp_pkg::sample_t sample_reg;

    assign s_tready = !valid_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_tvalid && s_tready) begin
            sample_reg <= s_tdata;
        end
    end

    assign hold.valid  = valid_reg;
    assign hold.sample = sample_reg;

endmodule

`default_nettype wire

// ----- design/sfcp_serializer.sv -----
`default_nettype none

// Sends the eight data bytes from a shift register, folding each into the CRC
// as it leaves, then the two CRC bytes.
module sfcp_serializer (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire sfcp_pkg::hold_t      hold,
    output logic                      take,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,
    output logic                      m_tlast
);

    logic                       active_reg;
    logic                       active_next;
    logic [sfcp_pkg::CNT_W-1:0] cnt_reg;
    logic [sfcp_pkg::CNT_W-1:0] cnt_next;
    logic [63:0]                data_reg;
    logic [63:0]                data_next;
    logic [15:0]                crc_reg;
    logic [15:0]                crc_next;
    logic [15:0]                crc_step;
    logic                       fire;
    logic                       last_fire;

    sfcp_crc_step u_crc (
        .crc_in  (crc_reg),
        .byte_in (data_reg[7:0]),
        .crc_out (crc_step)
    );

    assign fire      = active_reg && m_tready;
    assign last_fire = fire && (cnt_reg == sfcp_pkg::CRC_HI_IDX);
    assign take      = hold.valid && (!active_reg || last_fire);

    always_comb begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        data_next   = data_reg;
        crc_next    = crc_reg;
        if (take) begin
            active_next = 1'b1;
            cnt_next    = '0;
            data_next   = hold.sample;
            crc_next    = sfcp_pkg::CRC_SEED;
        end else if (last_fire) begin
            active_next = 1'b0;
        end else if (fire) begin
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg < sfcp_pkg::CRC_LO_IDX) begin
                data_next = {8'h00, data_reg[63:8]};
                crc_next  = crc_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
        end
        data_reg <= data_next;
        crc_reg  <= crc_next;
    end

    always_comb begin
        if (cnt_reg == sfcp_pkg::CRC_HI_IDX) begin
            m_tdata = crc_reg[15:8];
        end else if (cnt_reg == sfcp_pkg::CRC_LO_IDX) begin
            m_tdata = crc_reg[7:0];
        end else begin
            m_tdata = data_reg[7:0];
        end
    end

    assign m_tvalid = active_reg;
    assign m_tlast  = (cnt_reg == sfcp_pkg::CRC_HI_IDX);

endmodule

`default_nettype wire

// ----- design/sample_frame_crc16_packer.sv -----
`default_nettype none

// Channel  Direction  Payload
// s_       in         four 16-bit channel words, one item per frame
// m_       out        one frame byte per item, tlast on the tenth byte
//
// Each input item yields ten output items: the four channels low byte first,
// then the CRC-16/MODBUS of those eight bytes, low byte first.
// With m_tready held high the serializer sends one output byte per cycle, and
// frames follow each other without a gap while the next item is waiting.
// aresetn is synchronous and active low; it empties the input register and
// the serializer. A stall on m_ holds the current byte; one more item is
// taken on s_ while a frame is going out.
module sample_frame_crc16_packer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata, from bit 0: chan_zero, chan_one, chan_two, chan_three
    input  wire logic [63:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata, from bit 0: frame_byte
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);

    sfcp_pkg::hold_t hold;
    logic            take;

    // The input register frees itself when the serializer loads the sample.
    sfcp_in_buf u_in_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (take),
        .hold     (hold)
    );

    // The serializer loads a waiting sample while idle or in the same cycle its last byte leaves.
    sfcp_serializer u_serializer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .hold     (hold),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- design/sfcp_checker.sv -----
`default_nettype none

module sfcp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tlast
);

    logic [3:0] byte_cnt_reg;
    logic [1:0] pending_reg;
    logic       s_fire;
    logic       m_fire;

    assign s_fire      = s_tvalid && s_tready;
    assign m_fire      = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_cnt_reg <= '0;
            pending_reg  <= '0;
        end else begin
            if (m_fire) begin
                byte_cnt_reg <= m_tlast ? 4'd0 : byte_cnt_reg + 4'd1;
            end
            pending_reg <= pending_reg + {1'b0, s_fire} - {1'b0, m_fire && m_tlast};
        end
    end

    // A stalled byte stays offered and unchanged.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output byte changed");

    // The last flag comes on the tenth byte of a frame and nowhere else.
    a_tlast_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (byte_cnt_reg == 4'd9)))
        else $error("frame end flag not on the tenth byte");

    // Output bytes only belong to frames that were accepted.
    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 2'd0)
        else $error("output byte without an accepted item");

    // At most one frame waits behind the one going out.
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg != 2'd3 && (pending_reg != 2'd2 || !s_tready))
        else $error("more items held than the block can store");

endmodule

bind sample_frame_crc16_packer sfcp_checker u_sfcp_checker (.*);

`default_nettype wire
